// File: hdl/tcrm_pkg.sv
// ----------------------------------------------------------------------------
// tcrm_pkg
// Shared types and constants of the tick client rate multiplexer.
// ----------------------------------------------------------------------------
package tcrm_pkg;

  // table size and derived widths
  localparam int CLIENTS   = 8;
  localparam int IDX_W     = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int FIRE_W    = 8;
  localparam int KEY_W     = 16;
  localparam int US_W      = 20;
  localparam int KHZ_W     = 22;
  localparam int CYC_W     = 32;
  localparam int DIVD_W    = CYC_W;
  localparam int DCNT_W    = $clog2(DIVD_W + 1);

  localparam logic [KHZ_W-1:0] KHZ_RESET = KHZ_W'(1000000);
  localparam logic [CYC_W-1:0] US_PER_MS = CYC_W'(1000);

  // exact divide by 1000 through reciprocal multiplication
  // khz = kq * 1000 + kr, cycles = kq * us + (kr * us) / 1000
  localparam int KQ_W    = 13;
  localparam int KR_W    = 10;
  localparam int KRCP_W  = 23;
  localparam int KRCP_SH = 32;
  localparam logic [KRCP_W-1:0] KHZ_RECIP =
    KRCP_W'((64'd1 << KRCP_SH) / 64'(US_PER_MS) + 64'd1);
  localparam int LO_W    = KR_W + US_W;
  localparam int LRCP_W  = 31;
  localparam int LRCP_SH = 40;
  localparam logic [LRCP_W-1:0] LO_RECIP =
    LRCP_W'((64'd1 << LRCP_SH) / 64'(US_PER_MS) + 64'd1);
  localparam int HI_W    = KQ_W + US_W;
  localparam int SUM_W   = CYC_W + 2;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ENG_IDLE,
    ENG_MUL,
    ENG_CONV_GO,
    ENG_CONV_WAIT,
    ENG_CONV_DONE,
    ENG_SCAN,
    ENG_RATIO,
    ENG_RATIO_WAIT,
    ENG_PUSH
  } eng_state_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic [US_W-1:0]  us;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [FIRE_W-1:0] fire;
    logic              update;
    logic [CYC_W-1:0]  interval;
  } result_t;

endpackage

// File: hdl/tcrm_front.sv
// ----------------------------------------------------------------------------
// tcrm_front
// Input side: accepts items, decodes the command and holds them in a
// two-entry queue for the engine.
// ----------------------------------------------------------------------------
module tcrm_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            cmd,
  input  logic [15:0]           client_key,
  input  logic [19:0]           interval_us,
  output logic                  item_valid,
  output tcrm_pkg::item_t       item,
  input  logic                  item_ready
);
  import tcrm_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;
  item_t      decoded;

  // command decode
  always_comb begin
    decoded.key = client_key;
    decoded.us  = interval_us;
    decoded.cmd = cmd_t'(cmd);
  end

  assign full       = (cnt == 2'd2);
  assign item_valid = (cnt != 2'd0);
  assign item       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_valid && item_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= decoded;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: hdl/tcrm_div.sv
// ----------------------------------------------------------------------------
// tcrm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcrm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tcrm_pkg::DIVD_W-1:0] dividend,
  input  logic [tcrm_pkg::CYC_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [tcrm_pkg::DIVD_W-1:0] quotient
);
  import tcrm_pkg::*;

  logic [DIVD_W-1:0] quo;
  logic [CYC_W-1:0]  rem;
  logic [CYC_W-1:0]  dsr;
  logic [DCNT_W-1:0] cnt;
  logic [CYC_W:0]    trial;
  logic [CYC_W:0]    diff;
  logic              fits;

  // one trial subtraction
  assign trial    = {rem, quo[DIVD_W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign fits     = (trial >= {1'b0, dsr});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[CYC_W-1:0] : trial[CYC_W-1:0];
      quo <= {quo[DIVD_W-2:0], fits};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/tcrm_engine.sv
// ----------------------------------------------------------------------------
// tcrm_engine
// Back side: client table, tick countdowns, unit conversion, interval
// minimum and reload ratios, and the two-entry result queue.
// ----------------------------------------------------------------------------
module tcrm_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  tcrm_pkg::item_t            item,
  output logic                       item_ready,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tcrm_pkg::KHZ_W-1:0] cfg_data,
  output logic                       empty,
  input  logic                       pop,
  output tcrm_pkg::result_t          result
);
  import tcrm_pkg::*;

  // table and shared interval
  logic [KEY_W-1:0] slot_key    [CLIENTS];
  logic [CYC_W-1:0] slot_period [CLIENTS];
  logic [CYC_W-1:0] slot_count  [CLIENTS];
  logic [CYC_W-1:0] slot_reload [CLIENTS];
  logic [CYC_W-1:0] shared;
  logic [KHZ_W-1:0] clock_khz;

  // sequencer registers
  eng_state_t        state;
  eng_state_t        state_next;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  tgt;
  logic [KEY_W-1:0]  key_hold;
  logic [US_W-1:0]   us_hold;
  logic [CYC_W-1:0]  min_val;
  status_t           res_status;
  logic [FIRE_W-1:0] res_fire;
  logic              res_update;

  // conversion pipeline
  logic [KQ_W-1:0]         kq;
  logic [HI_W-1:0]         part_hi;
  logic [LO_W-1:0]         part_lo;
  logic [US_W-1:0]         lo_q;
  logic [KHZ_W+KRCP_W-1:0] kq_prod;
  logic [KHZ_W-1:0]        kr_full;
  logic [LO_W+LRCP_W-1:0]  lo_prod;
  logic [SUM_W-1:0]        conv_sum;

  // result queue
  result_t    outq [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] out_cnt;
  logic       out_push;
  logic       out_pop;

  // divider hookup
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [CYC_W-1:0]  div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;

  // table lookup
  logic [CLIENTS-1:0] live;
  logic [CLIENTS-1:0] match;
  logic               any_free;
  logic [IDX_W-1:0]   free_idx;
  logic               any_hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               last;
  logic [CYC_W-1:0]   cyc;
  logic [CYC_W-1:0]   scan_min;

  // tick datapath
  logic [CYC_W-1:0]   tick_count [CLIENTS];
  logic [CLIENTS-1:0] tick_fire;
  logic [FIRE_W-1:0]  tick_mask;

  tcrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // key compare and slot search
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    any_hit  = 1'b0;
    hit_idx  = '0;
    for (int i = CLIENTS - 1; i >= 0; i--) begin
      live[i]  = (slot_key[i] != '0);
      match[i] = (slot_key[i] == item.key);
      if (!live[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (live[i] && match[i]) begin
        any_hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign last = (idx == IDX_W'(CLIENTS - 1));

  // reciprocal products for the divide by 1000
  assign kq_prod  = (KHZ_W+KRCP_W)'(clock_khz) * (KHZ_W+KRCP_W)'(KHZ_RECIP);
  assign kr_full  = clock_khz - KHZ_W'(kq) * KHZ_W'(US_PER_MS);
  assign lo_prod  = (LO_W+LRCP_W)'(part_lo) * (LO_W+LRCP_W)'(LO_RECIP);
  assign conv_sum = SUM_W'(part_hi) + SUM_W'(lo_q);

  // conversion result: saturate, then clamp to one
  always_comb begin
    if (conv_sum[SUM_W-1:CYC_W] != '0) begin
      cyc = '1;
    end else if (conv_sum[CYC_W-1:0] == '0) begin
      cyc = CYC_W'(1);
    end else begin
      cyc = conv_sum[CYC_W-1:0];
    end
  end

  // running minimum for the remove scan
  always_comb begin
    scan_min = min_val;
    if (live[idx] && (min_val == '0 || slot_period[idx] < min_val)) begin
      scan_min = slot_period[idx];
    end
  end

  // per-slot countdown on a tick
  always_comb begin
    tick_mask = '0;
    for (int i = 0; i < CLIENTS; i++) begin
      tick_count[i] = slot_count[i];
      tick_fire[i]  = 1'b0;
      if (live[i]) begin
        tick_count[i] = slot_count[i] - 1'b1;
        if (tick_count[i] == '0) begin
          tick_count[i] = (shared == '0) ? slot_period[i] : slot_reload[i];
          tick_fire[i]  = 1'b1;
        end
      end
    end
    for (int b = 0; b < FIRE_W; b++) begin
      if (b < CLIENTS) begin
        tick_mask[b] = tick_fire[b];
      end
    end
  end

  // sequencer next state and strobes
  always_comb begin
    state_next   = state;
    item_ready   = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIVD_W'(slot_period[idx]);
    div_divisor  = shared;
    out_push     = 1'b0;
    case (state)
      ENG_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_next = ENG_PUSH;
          if (item.cmd == CMD_ADD && !(|match) && any_free) begin
            state_next = ENG_MUL;
          end else if (item.cmd == CMD_REMOVE && any_hit) begin
            state_next = ENG_SCAN;
          end
        end
      end
      ENG_MUL: begin
        state_next = ENG_CONV_GO;
      end
      ENG_CONV_GO: begin
        state_next = ENG_CONV_WAIT;
      end
      ENG_CONV_WAIT: begin
        state_next = ENG_CONV_DONE;
      end
      ENG_CONV_DONE: begin
        state_next = ENG_RATIO;
      end
      ENG_SCAN: begin
        if (last) begin
          state_next = (scan_min == '0) ? ENG_PUSH : ENG_RATIO;
        end
      end
      ENG_RATIO: begin
        if (live[idx]) begin
          div_start  = 1'b1;
          state_next = ENG_RATIO_WAIT;
        end else if (last) begin
          state_next = ENG_PUSH;
        end
      end
      ENG_RATIO_WAIT: begin
        if (div_done) begin
          state_next = last ? ENG_PUSH : ENG_RATIO;
        end
      end
      ENG_PUSH: begin
        if (out_cnt != 2'd2) begin
          out_push   = 1'b1;
          state_next = ENG_IDLE;
        end
      end
      default: begin
        state_next = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_khz <= KHZ_RESET;
    end else if (cfg_valid) begin
      clock_khz <= cfg_data;
    end
  end

  // table keys and shared interval
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLIENTS; i++) begin
        slot_key[i] <= '0;
      end
      shared <= '0;
    end else begin
      case (state)
        ENG_IDLE: begin
          if (item_valid && item.cmd == CMD_REMOVE && any_hit) begin
            slot_key[hit_idx] <= '0;
          end
        end
        ENG_CONV_DONE: begin
          slot_key[tgt] <= key_hold;
          if (shared == '0 || cyc < shared) begin
            shared <= cyc;
          end
        end
        ENG_SCAN: begin
          if (last) begin
            shared <= scan_min;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // slot payload and working registers
  always_ff @(posedge clk) begin
    case (state)
      ENG_IDLE: begin
        idx        <= '0;
        min_val    <= '0;
        res_status <= ST_OK;
        res_fire   <= '0;
        res_update <= 1'b0;
        tgt        <= free_idx;
        key_hold   <= item.key;
        us_hold    <= item.us;
        if (item_valid) begin
          case (item.cmd)
            CMD_TICK: begin
              for (int i = 0; i < CLIENTS; i++) begin
                slot_count[i] <= tick_count[i];
              end
              res_fire <= tick_mask;
            end
            CMD_ADD: begin
              if (|match) begin
                res_status <= ST_DUP;
              end else if (!any_free) begin
                res_status <= ST_FULL;
              end else begin
                res_update <= 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (!any_hit) begin
                res_status <= ST_MISSING;
              end else begin
                slot_period[hit_idx] <= '0;
                slot_count[hit_idx]  <= '0;
                res_update           <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ENG_MUL: begin
        kq <= kq_prod[KRCP_SH+KQ_W-1:KRCP_SH];
      end
      ENG_CONV_GO: begin
        part_hi <= HI_W'(kq) * HI_W'(us_hold);
        part_lo <= LO_W'(kr_full[KR_W-1:0]) * LO_W'(us_hold);
      end
      ENG_CONV_WAIT: begin
        lo_q <= lo_prod[LRCP_SH+US_W-1:LRCP_SH];
      end
      ENG_CONV_DONE: begin
        slot_period[tgt] <= cyc;
      end
      ENG_SCAN: begin
        min_val <= scan_min;
        idx     <= last ? '0 : idx + 1'b1;
      end
      ENG_RATIO: begin
        if (!live[idx]) begin
          slot_count[idx]  <= '0;
          slot_reload[idx] <= '0;
          if (!last) begin
            idx <= idx + 1'b1;
          end
        end
      end
      ENG_RATIO_WAIT: begin
        if (div_done) begin
          slot_count[idx]  <= div_quo[CYC_W-1:0];
          slot_reload[idx] <= div_quo[CYC_W-1:0];
          if (!last) begin
            idx <= idx + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result queue
  assign empty   = (out_cnt == 2'd0);
  assign result  = outq[rd_ptr];
  assign out_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (out_push) begin
      outq[wr_ptr] <= '{status: res_status, fire: res_fire,
                        update: res_update, interval: shared};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      out_cnt <= 2'd0;
    end else begin
      if (out_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      out_cnt <= out_cnt + {1'b0, out_push} - {1'b0, out_pop};
    end
  end

`ifndef SYNTHESIS
  // result queue never overfills
  a_outq_bound: assert property (@(posedge clk) disable iff (rst)
    out_cnt != 2'd3)
    else $error("result queue overflow");

  // divider only started when it is free
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // between transactions the shared interval is zero exactly when no client is live
  a_shared_live: assert property (@(posedge clk) disable iff (rst)
    (state == ENG_IDLE) |-> ((shared != '0) == (|live)))
    else $error("shared interval out of step with table");

  // a result is written only once per transaction
  a_one_push: assert property (@(posedge clk) disable iff (rst)
    out_push |=> !out_push)
    else $error("double result write");
`endif

endmodule

// File: hdl/tick_client_rate_multiplexer_core.sv
// ----------------------------------------------------------------------------
// tick_client_rate_multiplexer_core
// Table of periodic clients sharing one compare timer.
// ----------------------------------------------------------------------------
// Transactions are processed one at a time by the engine; two-entry queues on
// the input and result sides let either neighbor stall independently. A tick
// or a rejected request goes from the idle state straight to the result push.
// An accepted add runs the microsecond-to-cycle conversion (reciprocal
// multiplication) in the MUL, CONV_GO, CONV_WAIT and CONV_DONE states, then
// one divide per live client for its reload ratio and one step per free slot;
// a remove scans every slot for the minimum, then divides once per remaining
// client. The divides run on the single 32-bit divider, which retires one
// quotient bit per cycle.
module tick_client_rate_multiplexer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [15:0] client_key,
  input  logic [19:0] interval_us,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [7:0]  fire_mask,
  output logic        compare_update,
  output logic [31:0] compare_interval,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [21:0] cfg_data
);
  import tcrm_pkg::*;

  logic    item_valid;
  logic    item_ready;
  item_t   item;
  result_t result;

  tcrm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .client_key  (client_key),
    .interval_us (interval_us),
    .item_valid  (item_valid),
    .item        (item),
    .item_ready  (item_ready)
  );

  tcrm_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  // result fields
  assign status           = result.status;
  assign fire_mask        = result.fire;
  assign compare_update   = result.update;
  assign compare_interval = result.interval;

endmodule
